/* design/ppq_pkg.sv */
package ppq_pkg;

    localparam int HANDLE_W        = 8;
    localparam int PRIO_W          = 4;
    localparam int RUN_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int PRIORITY_LEVELS = 16;
    localparam int STACK_IDX_W     = 4;
    localparam int STACK_DEPTH_W   = 5;
    localparam logic [RUN_W-1:0] IDLE_LEVEL = RUN_W'(PRIORITY_LEVELS);

    typedef enum logic [1:0] {
        OPC_ADD      = 2'd0,
        OPC_DISPATCH = 2'd1,
        OPC_FINISH   = 2'd2,
        OPC_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NOT_URGENT = 3'd3,
        ST_NOT_RUN    = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t             op;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* design/ppq_front.sv */
module ppq_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [ppq_pkg::HANDLE_W-1:0] s_task_handle,
    input  logic [ppq_pkg::PRIO_W-1:0]   s_task_priority,
    input  ppq_pkg::fifo_status_t        fifo_status,
    output logic                         push,
    output ppq_pkg::cmd_t                push_cmd
);
    import ppq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    cmd_t    cmd_reg;
    cmd_t    cmd_next;
    opcode_t op_dec;

    // every 2-bit value is a member, the unused one decodes to OPC_NONE
    assign op_dec = opcode_t'(s_opcode);

    assign push     = valid_reg && !fifo_status.full;
    assign s_ready  = !valid_reg || !fifo_status.full;
    assign push_cmd = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            cmd_next.op     = op_dec;
            cmd_next.handle = s_task_handle;
            // priority only matters for an add
            cmd_next.prio   = (op_dec == OPC_ADD) ? s_task_priority : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

/* design/ppq_fifo.sv */
module ppq_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ppq_pkg::cmd_t         push_cmd,
    output ppq_pkg::fifo_status_t fifo_status,
    input  logic                  pop,
    output ppq_pkg::cmd_t         pop_cmd
);
    import ppq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign fifo_status.full  = (count_reg == 2'd2);
    assign fifo_status.empty = (count_reg == 2'd0);
    assign pop_cmd           = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/ppq_back.sv */
module ppq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ppq_pkg::fifo_status_t        fifo_status,
    input  ppq_pkg::cmd_t                pop_cmd,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppq_pkg::STATUS_W-1:0] m_status,
    output logic [ppq_pkg::HANDLE_W-1:0] m_dispatched_handle,
    output logic [ppq_pkg::PRIO_W-1:0]   m_dispatched_priority,
    output logic [ppq_pkg::RUN_W-1:0]    m_running_priority
);
    import ppq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sorted entries, head at index zero
    logic [PRIO_W-1:0]   prio_reg   [QUEUE_DEPTH];
    logic [PRIO_W-1:0]   prio_next  [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] handle_reg [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] handle_next[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] keep;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [RUN_W-1:0]         cur_reg;
    logic [RUN_W-1:0]         cur_next;
    logic [RUN_W-1:0]         stack_reg [PRIORITY_LEVELS];
    logic [STACK_DEPTH_W-1:0] depth_reg;
    logic [STACK_DEPTH_W-1:0] depth_next;
    logic [STACK_DEPTH_W-1:0] depth_dec;

    logic                m_valid_reg;
    logic                m_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [HANDLE_W-1:0] hd_reg;
    logic [HANDLE_W-1:0] hd_next;
    logic [PRIO_W-1:0]   pr_reg;
    logic [PRIO_W-1:0]   pr_next;
    logic [RUN_W-1:0]    run_reg;

    logic do_insert;
    logic do_remove;
    logic do_push;

    assign pop       = !fifo_status.empty && (!m_valid_reg || m_ready);
    assign depth_dec = depth_reg - STACK_DEPTH_W'(1);

    // entry i stays put when it is valid and not less urgent than the new task
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
        assign keep[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= pop_cmd.prio);

        always_comb begin
            prio_next[i]   = prio_reg[i];
            handle_next[i] = handle_reg[i];
            if (do_insert && !keep[i]) begin
                if (i == 0) begin
                    prio_next[i]   = pop_cmd.prio;
                    handle_next[i] = pop_cmd.handle;
                end else if (keep[(i == 0) ? 0 : i - 1]) begin
                    prio_next[i]   = pop_cmd.prio;
                    handle_next[i] = pop_cmd.handle;
                end else begin
                    prio_next[i]   = prio_reg[(i == 0) ? 0 : i - 1];
                    handle_next[i] = handle_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (do_remove && (i < QUEUE_DEPTH - 1)) begin
                prio_next[i]   = prio_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                handle_next[i] = handle_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        do_push     = 1'b0;
        status_next = ST_OK;
        hd_next     = '0;
        pr_next     = '0;
        count_next  = count_reg;
        cur_next    = cur_reg;
        depth_next  = depth_reg;
        if (pop) begin
            case (pop_cmd.op)
                OPC_ADD: begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        do_insert  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OPC_DISPATCH: begin
                    if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else if ({1'b0, prio_reg[0]} >= cur_reg ||
                                 depth_reg >= STACK_DEPTH_W'(PRIORITY_LEVELS)) begin
                        status_next = ST_NOT_URGENT;
                    end else begin
                        do_remove  = 1'b1;
                        do_push    = 1'b1;
                        hd_next    = handle_reg[0];
                        pr_next    = prio_reg[0];
                        count_next = count_reg - CNT_W'(1);
                        cur_next   = {1'b0, prio_reg[0]};
                        depth_next = depth_reg + STACK_DEPTH_W'(1);
                    end
                end
                OPC_FINISH: begin
                    if (depth_reg == '0) begin
                        status_next = ST_NOT_RUN;
                    end else begin
                        depth_next = depth_dec;
                        cur_next   = stack_reg[depth_dec[STACK_IDX_W-1:0]];
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cur_reg     <= IDLE_LEVEL;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            prio_reg[k]   <= prio_next[k];
            handle_reg[k] <= handle_next[k];
        end
        if (do_push) begin
            stack_reg[depth_reg[STACK_IDX_W-1:0]] <= cur_reg;
        end
        if (pop) begin
            status_reg <= status_next;
            hd_reg     <= hd_next;
            pr_reg     <= pr_next;
            run_reg    <= cur_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_status              = status_reg;
    assign m_dispatched_handle   = hd_reg;
    assign m_dispatched_priority = pr_reg;
    assign m_running_priority    = run_reg;

endmodule

/* design/preemptive_priority_task_queue_top.sv */
// path: a word accepted on s_ passes the front register and the two-word queue, then is registered onto m_
// throughput: one word per cycle while m_ready stays high; each op updates the whole sorted entry row at once
// the front stage and a two-word queue let input and result sides stall on their own
// reset (aresetn low, synchronous): queue empty, nothing running (level 16),
// nesting depth zero, no result pending
module preemptive_priority_task_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [ppq_pkg::HANDLE_W-1:0] s_task_handle,
    input  logic [ppq_pkg::PRIO_W-1:0]   s_task_priority,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppq_pkg::STATUS_W-1:0] m_status,
    output logic [ppq_pkg::HANDLE_W-1:0] m_dispatched_handle,
    output logic [ppq_pkg::PRIO_W-1:0]   m_dispatched_priority,
    output logic [ppq_pkg::RUN_W-1:0]    m_running_priority
);
    import ppq_pkg::*;

    fifo_status_t fifo_status;
    logic         push;
    logic         pop;
    cmd_t         push_cmd;
    cmd_t         pop_cmd;

    ppq_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_task_handle   (s_task_handle),
        .s_task_priority (s_task_priority),
        .fifo_status     (fifo_status),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ppq_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_cmd    (push_cmd),
        .fifo_status (fifo_status),
        .pop         (pop),
        .pop_cmd     (pop_cmd)
    );

    ppq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .fifo_status           (fifo_status),
        .pop_cmd               (pop_cmd),
        .pop                   (pop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_dispatched_handle   (m_dispatched_handle),
        .m_dispatched_priority (m_dispatched_priority),
        .m_running_priority    (m_running_priority)
    );

endmodule
